// File: design/bdpp_pkg.sv
// Shared types, constants and the reciprocal table for the box downsample pixel packer.
package bdpp_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		REG_FACTOR   = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_FORMAT   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic accept;
		logic acc_en;
		logic mul_en;
		logic out_load;
		logic cfg_we;
	} cmd_t;

	typedef struct packed {
		logic last_block;
		logic out_free;
	} stat_t;

	localparam logic       FMT_BGRA     = 1'b0;
	localparam logic [7:0] ALPHA_BYTE   = 8'hff;
	localparam logic [2:0] BYTES_BGRA   = 3'd4;
	localparam logic [2:0] BYTES_RGB    = 3'd3;
	localparam int         HEIGHT_LIMIT = 2048;
	localparam int         SUM_W        = 14;
	localparam int         RECIP_SHIFT  = 22;
	localparam int         RECIP_W      = 23;
	localparam int         RecipOne     = 1 << RECIP_SHIFT;

	// Rounded-up reciprocal of factor squared, scaled by two to the RECIP_SHIFT.
	// With a sum of at most SUM_W bits the truncated product equals the quotient.
	function automatic logic [RECIP_W-1:0] recip_for(input logic [4:0] f);
		logic [RECIP_W-1:0] r;
		case (f)
			5'd2:  r = RECIP_W'((RecipOne + 4 - 1) / 4);
			5'd3:  r = RECIP_W'((RecipOne + 9 - 1) / 9);
			5'd4:  r = RECIP_W'((RecipOne + 16 - 1) / 16);
			5'd5:  r = RECIP_W'((RecipOne + 25 - 1) / 25);
			5'd6:  r = RECIP_W'((RecipOne + 36 - 1) / 36);
			5'd7:  r = RECIP_W'((RecipOne + 49 - 1) / 49);
			5'd8:  r = RECIP_W'((RecipOne + 64 - 1) / 64);
			5'd9:  r = RECIP_W'((RecipOne + 81 - 1) / 81);
			5'd10: r = RECIP_W'((RecipOne + 100 - 1) / 100);
			5'd11: r = RECIP_W'((RecipOne + 121 - 1) / 121);
			5'd12: r = RECIP_W'((RecipOne + 144 - 1) / 144);
			5'd13: r = RECIP_W'((RecipOne + 169 - 1) / 169);
			5'd14: r = RECIP_W'((RecipOne + 196 - 1) / 196);
			5'd15: r = RECIP_W'((RecipOne + 225 - 1) / 225);
			5'd16: r = RECIP_W'((RecipOne + 256 - 1) / 256);
			default: r = RECIP_W'(RecipOne);
		endcase
		return r;
	endfunction

endpackage

// File: design/bdpp_ctrl.sv
// Controller FSM: read and accumulate per subpixel, divide and output per block.
module bdpp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  bdpp_pkg::stat_t stat,
	output bdpp_pkg::cmd_t  cmd
);

	bdpp_pkg::state_t state_q;
	bdpp_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bdpp_pkg::ST_IDLE: begin
				if (s_tvalid && !cfg_valid) begin
					state_nxt = bdpp_pkg::ST_ACC;
				end
			end
			bdpp_pkg::ST_ACC: begin
				state_nxt = stat.last_block ? bdpp_pkg::ST_MUL : bdpp_pkg::ST_IDLE;
			end
			bdpp_pkg::ST_MUL: begin
				state_nxt = bdpp_pkg::ST_OUT;
			end
			bdpp_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_nxt = bdpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bdpp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cfg_ready    = 1'b0;
		cmd          = '0;
		case (state_q)
			bdpp_pkg::ST_IDLE: begin
				s_tready   = !cfg_valid;
				cfg_ready  = 1'b1;
				cmd.accept = s_tvalid && !cfg_valid;
				cmd.cfg_we = cfg_valid;
			end
			bdpp_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
			end
			bdpp_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			bdpp_pkg::ST_OUT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: design/bdpp_datapath.sv
// Datapath: configuration registers, raster counters, line accumulators, divider and output register.
module bdpp_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_FACTOR = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bdpp_pkg::cmd_t  cmd,
	output bdpp_pkg::stat_t stat,
	input  logic [1:0]      cfg_index,
	input  logic [11:0]     cfg_data,
	input  logic [23:0]     s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [63:0]     m_tdata
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int SUM_W = bdpp_pkg::SUM_W;
	localparam int PROD_W = SUM_W + bdpp_pkg::RECIP_W;
	localparam int QLO = bdpp_pkg::RECIP_SHIFT;

	logic [3:0]  factor_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic        format_q;

	logic [4:0]  f_eff;
	logic [11:0] w_eff;
	logic [11:0] h_eff;

	logic [SW-1:0] sub_col_q;
	logic [SW-1:0] sub_row_q;
	logic [AW-1:0] col_q;
	logic [10:0]   block_row_q;

	logic [SW:0]   sub_col_inc;
	logic [SW:0]   sub_row_inc;
	logic [AW:0]   col_inc;
	logic [11:0]   block_row_inc;
	logic          col_done;
	logic          row_done;

	logic [3*SUM_W-1:0] mem [MAX_WIDTH];
	logic [3*SUM_W-1:0] rd_s1;

	logic [23:0]   pix_s1;
	logic [AW-1:0] addr_s1;
	logic          first_s1;
	logic          last_s1;
	logic [10:0]   row_tag_s1;
	logic [10:0]   col_tag_s1;

	logic [SUM_W-1:0] red_sum;
	logic [SUM_W-1:0] green_sum;
	logic [SUM_W-1:0] blue_sum;
	logic [SUM_W-1:0] red_s2;
	logic [SUM_W-1:0] green_s2;
	logic [SUM_W-1:0] blue_s2;

	logic [bdpp_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0] red_prod;
	logic [PROD_W-1:0] green_prod;
	logic [PROD_W-1:0] blue_prod;
	logic [7:0] red_s3;
	logic [7:0] green_s3;
	logic [7:0] blue_s3;

	logic        out_valid_q;
	logic [63:0] out_data_q;

	always_comb begin
		f_eff = 5'(factor_q);
		if (factor_q == 4'd0) begin
			f_eff = 5'd1;
		end else if (factor_q > MAX_FACTOR) begin
			f_eff = 5'(MAX_FACTOR);
		end
		w_eff = width_q;
		if (width_q == 12'd0) begin
			w_eff = 12'd1;
		end else if (width_q > MAX_WIDTH) begin
			w_eff = 12'(MAX_WIDTH);
		end
		h_eff = height_q;
		if (height_q == 12'd0) begin
			h_eff = 12'd1;
		end else if (height_q > bdpp_pkg::HEIGHT_LIMIT) begin
			h_eff = 12'(bdpp_pkg::HEIGHT_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= 4'd1;
			width_q  <= 12'd1;
			height_q <= 12'd1;
			format_q <= bdpp_pkg::FMT_BGRA;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				bdpp_pkg::REG_FACTOR: factor_q <= cfg_data[3:0];
				bdpp_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bdpp_pkg::REG_HEIGHT: height_q <= cfg_data;
				bdpp_pkg::REG_FORMAT: format_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sub_col_inc   = {1'b0, sub_col_q} + 1'b1;
	assign sub_row_inc   = {1'b0, sub_row_q} + 1'b1;
	assign col_inc       = {1'b0, col_q} + 1'b1;
	assign block_row_inc = {1'b0, block_row_q} + 1'b1;
	assign col_done      = sub_col_inc >= f_eff;
	assign row_done      = sub_row_inc >= f_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_col_q   <= '0;
			sub_row_q   <= '0;
			col_q       <= '0;
			block_row_q <= '0;
		end else if (cmd.cfg_we) begin
			sub_col_q   <= '0;
			sub_row_q   <= '0;
			col_q       <= '0;
			block_row_q <= '0;
		end else if (cmd.accept) begin
			if (col_done) begin
				sub_col_q <= '0;
				if (col_inc >= w_eff) begin
					col_q <= '0;
					if (row_done) begin
						sub_row_q   <= '0;
						block_row_q <= (block_row_inc >= h_eff) ? 11'd0 : block_row_inc[10:0];
					end else begin
						sub_row_q <= sub_row_inc[SW-1:0];
					end
				end else begin
					col_q <= col_inc[AW-1:0];
				end
			end else begin
				sub_col_q <= sub_col_inc[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_s1      <= mem[col_q];
			pix_s1     <= s_tdata;
			addr_s1    <= col_q;
			first_s1   <= (sub_row_q == '0) && (sub_col_q == '0);
			last_s1    <= row_done && col_done;
			row_tag_s1 <= 11'(h_eff - 12'd1 - {1'b0, block_row_q});
			col_tag_s1 <= 11'(col_q);
		end
	end

	always_comb begin
		if (first_s1) begin
			red_sum   = SUM_W'(pix_s1[7:0]);
			green_sum = SUM_W'(pix_s1[15:8]);
			blue_sum  = SUM_W'(pix_s1[23:16]);
		end else begin
			red_sum   = rd_s1[SUM_W-1:0] + SUM_W'(pix_s1[7:0]);
			green_sum = rd_s1[2*SUM_W-1:SUM_W] + SUM_W'(pix_s1[15:8]);
			blue_sum  = rd_s1[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_s1[23:16]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			mem[addr_s1] <= {blue_sum, green_sum, red_sum};
			red_s2       <= red_sum;
			green_s2     <= green_sum;
			blue_s2      <= blue_sum;
		end
	end

	assign recip      = bdpp_pkg::recip_for(f_eff);
	assign red_prod   = PROD_W'(red_s2) * PROD_W'(recip);
	assign green_prod = PROD_W'(green_s2) * PROD_W'(recip);
	assign blue_prod  = PROD_W'(blue_s2) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			red_s3   <= red_prod[QLO+7:QLO];
			green_s3 <= green_prod[QLO+7:QLO];
			blue_s3  <= blue_prod[QLO+7:QLO];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (format_q == bdpp_pkg::FMT_BGRA) begin
				out_data_q <= {7'd0, col_tag_s1, row_tag_s1, bdpp_pkg::BYTES_BGRA,
					bdpp_pkg::ALPHA_BYTE, red_s3, green_s3, blue_s3};
			end else begin
				out_data_q <= {7'd0, col_tag_s1, row_tag_s1, bdpp_pkg::BYTES_RGB,
					8'd0, blue_s3, green_s3, red_s3};
			end
		end
	end

	assign stat.last_block = last_s1;
	assign stat.out_free   = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;

endmodule

// File: design/box_downsample_pixel_packer.sv
// Top level of the box downsample pixel packer: controller and datapath.
// Subpixels arrive in raster order, bottom subrow first; each factor-by-factor block is summed
// per channel in a single-port line memory and the last subpixel of a block yields one packed
// pixel. A subpixel that does not complete a block takes a line memory read, then accumulate
// and write back; one that completes a block also takes the reciprocal multiply and the
// output register load, which waits until the output register is free or m_tready is high.
// The output register lets the next subpixel be taken while a pixel is still waiting.
// Configuration writes are taken whenever no subpixel is in progress and restart the frame.
module box_downsample_pixel_packer #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_FACTOR = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // byte0, byte1, byte2, byte3, byte_count [34:32],
	                               // out_row [45:35], out_col [56:46], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	bdpp_pkg::cmd_t  cmd;
	bdpp_pkg::stat_t stat;

	bdpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdpp_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: design/bdpp_checker.sv
// Port-level checker for the box downsample pixel packer, bound to the top level.
module bdpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// A waiting pixel must hold until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output pixel changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] == 3'd4 || m_tdata[34:32] == 3'd3))
		else $error("byte count is neither three nor four");

	// The fourth byte carries alpha in the four-byte format and is zero otherwise.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[34:32] == 3'd4 && m_tdata[31:24] == 8'hff)
			|| (m_tdata[34:32] == 3'd3 && m_tdata[31:24] == 8'h00)))
		else $error("fourth byte does not match the pixel format");

	// Each subpixel needs a read and then a write-back before the next is taken.
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("subpixel accepted on consecutive cycles");

endmodule

bind box_downsample_pixel_packer bdpp_checker u_bdpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/tb_box_downsample_pixel_packer.sv
// Testbench for the box downsample pixel packer: pixel predictor, stimulus and result checks.
module tb_box_downsample_pixel_packer;
	import bdpp_pkg::*;

	localparam int MaxWidth     = 2048;
	localparam int MaxFactor    = 8;
	localparam int DrainCycles  = 16;
	localparam int HoldCycles   = 300;
	localparam int CycleLimit   = 400000;
	localparam int RandomItems  = 700;
	localparam int MaxReports   = 50;

	typedef struct packed {
		logic [6:0]  pad;
		logic [10:0] out_col;
		logic [10:0] out_row;
		logic [2:0]  byte_count;
		logic [7:0]  byte3;
		logic [7:0]  byte2;
		logic [7:0]  byte1;
		logic [7:0]  byte0;
	} pixel_word_t;

	class pixel_scoreboard;
		logic [3:0]  factor_q;
		logic [11:0] width_q;
		logic [11:0] height_q;
		logic        format_q;
		logic [13:0] red_sum [MaxWidth];
		logic [13:0] green_sum [MaxWidth];
		logic [13:0] blue_sum [MaxWidth];
		int unsigned sub_col;
		int unsigned sub_row;
		int unsigned col_pos;
		int unsigned block_row;
		pixel_word_t expected_pixels [$];
		int errors;
		int checked;

		function new();
			factor_q = 4'd1;
			width_q = 12'd1;
			height_q = 12'd1;
			format_q = FMT_BGRA;
			errors = 0;
			checked = 0;
			restart_frame();
		endfunction

		function void restart_frame();
			sub_col = 0;
			sub_row = 0;
			col_pos = 0;
			block_row = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void write_reg(reg_index_t idx, logic [11:0] val);
			case (idx)
				REG_FACTOR: factor_q = val[3:0];
				REG_WIDTH:  width_q = val;
				REG_HEIGHT: height_q = val;
				REG_FORMAT: format_q = val[0];
				default: ;
			endcase
			restart_frame();
		endfunction

		function void note_subpixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned f, w, h, c, area, br;
			logic [7:0] rq, gq, bq;
			pixel_word_t px;
			f = clip(factor_q, MaxFactor);
			w = clip(width_q, MaxWidth);
			h = clip(height_q, HEIGHT_LIMIT);
			c = (col_pos >= w) ? w - 1 : col_pos;
			if (sub_row == 0 && sub_col == 0) begin
				red_sum[c] = 14'(r);
				green_sum[c] = 14'(g);
				blue_sum[c] = 14'(b);
			end else begin
				red_sum[c] = red_sum[c] + 14'(r);
				green_sum[c] = green_sum[c] + 14'(g);
				blue_sum[c] = blue_sum[c] + 14'(b);
			end
			if (sub_row + 1 >= f && sub_col + 1 >= f) begin
				area = f * f;
				rq = 8'(32'(red_sum[c]) / area);
				gq = 8'(32'(green_sum[c]) / area);
				bq = 8'(32'(blue_sum[c]) / area);
				br = (block_row < h) ? block_row : h - 1;
				px = '0;
				px.byte1 = gq;
				if (format_q == FMT_BGRA) begin
					px.byte0 = bq;
					px.byte2 = rq;
					px.byte3 = ALPHA_BYTE;
					px.byte_count = BYTES_BGRA;
				end else begin
					px.byte0 = rq;
					px.byte2 = bq;
					px.byte_count = BYTES_RGB;
				end
				px.out_row = 11'(h - 1 - br);
				px.out_col = 11'(c);
				expected_pixels.push_back(px);
			end
			if (sub_col + 1 >= f) begin
				sub_col = 0;
				if (c + 1 >= w) begin
					col_pos = 0;
					if (sub_row + 1 >= f) begin
						sub_row = 0;
						block_row = (block_row + 1 >= h) ? 0 : block_row + 1;
					end else begin
						sub_row++;
					end
				end else begin
					col_pos = c + 1;
				end
			end else begin
				sub_col++;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MaxReports)
				$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("pixel %0d %s got %0h want %0h", checked, name, got, want));
		endtask

		task check_pixel(pixel_word_t got);
			pixel_word_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel %0h arrived with none expected", got));
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("byte0", 16'(got.byte0), 16'(want.byte0));
			compare_field("byte1", 16'(got.byte1), 16'(want.byte1));
			compare_field("byte2", 16'(got.byte2), 16'(want.byte2));
			compare_field("byte3", 16'(got.byte3), 16'(want.byte3));
			compare_field("byte_count", 16'(got.byte_count), 16'(want.byte_count));
			compare_field("out_row", 16'(got.out_row), 16'(want.out_row));
			compare_field("out_col", 16'(got.out_col), 16'(want.out_col));
			compare_field("zero fill", 16'(got.pad), 16'(want.pad));
			checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;

	pixel_scoreboard sb = new();
	int          src_max_gap;
	int          sink_max_gap;
	bit          hold_req;
	int          random_items;
	int unsigned cycle_count = 0;

	box_downsample_pixel_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_subpixel(r, g, b);
	endtask

	task automatic send_random_pixel();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			send_pixel(8'hff, 8'hff, 8'hff);
		else if (pick == 1)
			send_pixel(8'h00, 8'h00, 8'h00);
		else
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic program_reg(reg_index_t idx, logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [3:0] mask, logic [11:0] f, logic [11:0] w,
			logic [11:0] h, logic [11:0] fmt);
		if (mask == 4'b0000)
			return;
		settle();
		if (mask[0])
			program_reg(REG_FACTOR, f);
		if (mask[1])
			program_reg(REG_WIDTH, w);
		if (mask[2])
			program_reg(REG_HEIGHT, h);
		if (mask[3])
			program_reg(REG_FORMAT, fmt);
	endtask

	task automatic random_phase();
		int pick, fe, we, len, n;
		logic [11:0] f, w, h, fmt;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			f = 12'($urandom_range(1, 4));
		else if (pick < 88)
			f = 12'($urandom_range(5, 8));
		else if (pick < 94)
			f = 12'd0;
		else
			f = 12'($urandom_range(9, 15));
		f[11:4] = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 80)
			w = 12'($urandom_range(1, 6));
		else if (pick < 88)
			w = 12'($urandom_range(7, 40));
		else if (pick < 94)
			w = 12'd0;
		else
			w = 12'($urandom_range(2048, 4095));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			h = 12'($urandom_range(1, 5));
		else if (pick < 80)
			h = 12'd0;
		else if (pick < 90)
			h = 12'($urandom_range(2040, 2048));
		else
			h = 12'($urandom);
		fmt = 12'($urandom);
		apply_settings(4'($urandom), f, w, h, fmt);
		src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
		sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
		fe = sb.clip(sb.factor_q, MaxFactor);
		we = sb.clip(sb.width_q, MaxWidth);
		len = fe * fe * we;
		if (len <= 128) begin
			n = len * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, fe * fe);
		end else begin
			n = $urandom_range(10, 60);
		end
		repeat (n) send_random_pixel();
		random_items += n;
	endtask

	initial begin : sink_side
		int sink_wait;
		int hold_left;
		sink_wait = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_pixel(pixel_word_t'(m_tdata));
				sink_wait = (sink_max_gap == 0) ? 0 : $urandom_range(0, sink_max_gap);
			end
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FACTOR;
		cfg_data <= '0;
		src_max_gap = 18;
		sink_max_gap = 18;
		hold_req = 1'b0;
		random_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings after reset: one subpixel per pixel, one row, four-byte format.
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h55, 8'haa, 8'h0f);
		send_pixel(8'haa, 8'h55, 8'hf0);

		apply_settings(4'b1000, 12'd0, 12'd0, 12'd0, 12'h001);
		send_pixel(8'h12, 8'h34, 8'h56);
		send_pixel(8'hff, 8'h00, 8'h80);

		// Two by two blocks over two block columns: each mixes full-scale and small subpixels, so averages truncate.
		apply_settings(4'b1111, 12'h002, 12'h002, 12'h002, 12'h000);
		repeat (4) send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h01, 8'h02, 8'h03);
		send_pixel(8'h00, 8'h01, 8'hff);
		send_pixel(8'h02, 8'h00, 8'hfe);
		send_pixel(8'h00, 8'h00, 8'h01);

		// Zero factor, width and height all behave as one.
		apply_settings(4'b0111, 12'hff0, 12'h000, 12'h000, 12'h000);
		send_pixel(8'h80, 8'h40, 8'h20);
		send_pixel(8'h7f, 8'hbf, 8'hdf);

		// Oversized width and height saturate; the first block row gets the highest row index.
		apply_settings(4'b1111, 12'h001, 12'hfff, 12'hfff, 12'h7ff);
		repeat (3) send_random_pixel();

		// A small frame that wraps back to its first block row.
		apply_settings(4'b1110, 12'h001, 12'h002, 12'h002, 12'h000);
		repeat (6) send_random_pixel();

		// The receiver holds off while subpixels keep coming, so the input stalls.
		apply_settings(4'b1111, 12'h001, 12'h004, 12'h003, 12'h000);
		src_max_gap = 0;
		sink_max_gap = 0;
		hold_req = 1'b1;
		repeat (40) send_random_pixel();
		random_items += 40;

		while (random_items < RandomItems)
			random_phase();

		settle();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
design/bdpp_pkg.sv
design/bdpp_ctrl.sv
design/bdpp_datapath.sv
design/box_downsample_pixel_packer.sv
design/bdpp_checker.sv
test/tb_box_downsample_pixel_packer.sv
